>>> hdl/kws_pkg.sv
// Shared types and constants for the k-mer window sampler.
`default_nettype none
package kws_pkg;

  localparam int MAX_KMER  = 32;
  localparam int POS_WIDTH = 32;

  localparam int K_W    = 6;
  localparam int W_W    = 10;
  localparam int FILL_W = $clog2(MAX_KMER + 1);
  localparam int HIST_W = 2 * MAX_KMER;
  localparam int CODE_W = 64;
  localparam int P_W    = 32;

  // Offsets wrap to POS_WIDTH bits, then to the 32-bit port.
  localparam logic [P_W-1:0] POS_MASK =
    (POS_WIDTH >= P_W) ? '1 : P_W'((64'd1 << POS_WIDTH) - 64'd1);

  typedef logic [1:0]        base_t;
  typedef logic [P_W-1:0]    pos_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [HIST_W-1:0] hist_t;
  typedef logic [K_W-1:0]    ksize_t;
  typedef logic [W_W-1:0]    wsize_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [W_W-1:0]    cfg_data_t;

  typedef enum logic [0:0] {
    CFG_KMER_SIZE   = 1'b0,
    CFG_WINDOW_SIZE = 1'b1
  } cfg_index_t;

endpackage
`default_nettype wire

>>> hdl/kws_if.sv
// Valid/ready channels for bases in and sampled k-mers out.
`default_nettype none
interface kws_base_if;
  import kws_pkg::*;
  logic  valid;
  logic  ready;
  base_t base;
  logic  first_of_seq;
  pos_t  base_pos;
  modport source (output valid, output base, output first_of_seq, output base_pos,
                  input ready);
  modport sink   (input valid, input base, input first_of_seq, input base_pos,
                  output ready);
endinterface

interface kws_kmer_if;
  import kws_pkg::*;
  logic  valid;
  logic  ready;
  code_t kmer_code;
  pos_t  kmer_pos;
  modport source (output valid, output kmer_code, output kmer_pos, input ready);
  modport sink   (input valid, input kmer_code, input kmer_pos, output ready);
endinterface
`default_nettype wire

>>> hdl/kmer_window_sampler_core.sv
// Top level: fixed-stride k-mer sampler over a stream of 2-bit bases.
`default_nettype none
// Takes one base per clock and returns zero or one k-mer per base. A base is
// accepted in every cycle in which the single output register is empty or its
// request is being taken, so the sustained rate is one base per cycle; a
// k-mer shows on the output in the cycle after the base that completes it.
// The first full k-mer of each sequence is sent, then one every stride bases.
// The user must write the k-mer length and stride via cfg only while idle; the
// block does not enforce it. Zero is read as 1, a k-mer length above 32 as 32.
module kmer_window_sampler_core (
  input  wire logic            clk,
  input  wire logic            rst,
  kws_base_if.sink             bases,
  kws_kmer_if.source           kmers,
  input  wire logic            cfg_we,
  input  kws_pkg::cfg_index_t  cfg_index,
  input  kws_pkg::cfg_data_t   cfg_data
);
  import kws_pkg::*;

  ksize_t kmer_len;
  wsize_t stride;

  hist_t  history;
  fill_t  filled;
  wsize_t since_emit;
  logic   emitted;

  hist_t  history_next;
  fill_t  filled_next;
  wsize_t since_emit_next;
  logic   emitted_next;

  ksize_t k_eff;
  wsize_t w_eff;
  fill_t  fill_base;
  wsize_t since_base;
  wsize_t since_inc;
  logic   emitted_base;
  logic   emit;
  hist_t  code_mask;
  logic   in_acc;

  logic   out_valid;
  code_t  out_code;
  pos_t   out_pos;

  assign bases.ready = !out_valid || kmers.ready;
  assign in_acc      = bases.valid && bases.ready;

  assign kmers.valid     = out_valid;
  assign kmers.kmer_code = out_code;
  assign kmers.kmer_pos  = out_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= K_W'(15);
      stride   <= W_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KMER_SIZE:   kmer_len <= cfg_data[K_W-1:0];
        CFG_WINDOW_SIZE: stride   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (kmer_len == '0)                   k_eff = K_W'(1);
    else if (kmer_len > K_W'(MAX_KMER))   k_eff = K_W'(MAX_KMER);
    else                                  k_eff = kmer_len;
    w_eff = (stride == '0) ? W_W'(1) : stride;
  end

  always_comb begin
    for (int i = 0; i < MAX_KMER; i++) begin
      code_mask[2*i +: 2] = (K_W'(i) < k_eff) ? 2'b11 : 2'b00;
    end
  end

  // A start flag clears the sequence state before this base is shifted in.
  always_comb begin
    fill_base    = bases.first_of_seq ? '0 : filled;
    since_base   = bases.first_of_seq ? '0 : since_emit;
    emitted_base = bases.first_of_seq ? 1'b0 : emitted;
    history_next = ((bases.first_of_seq ? '0 : history) << 2)
                   | HIST_W'(bases.base);
    filled_next  = (fill_base < FILL_W'(MAX_KMER)) ? fill_base + FILL_W'(1) : fill_base;
    since_inc    = since_base + W_W'(1);

    emit            = 1'b0;
    emitted_next    = emitted_base;
    since_emit_next = since_base;
    if (K_W'(filled_next) >= k_eff) begin
      if (!emitted_base) begin
        emit            = 1'b1;
        emitted_next    = 1'b1;
        since_emit_next = '0;
      end else if (since_inc >= w_eff) begin
        emit            = 1'b1;
        since_emit_next = '0;
      end else begin
        since_emit_next = since_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= '0;
      filled     <= '0;
      since_emit <= '0;
      emitted    <= 1'b0;
    end else if (in_acc) begin
      history    <= history_next;
      filled     <= filled_next;
      since_emit <= since_emit_next;
      emitted    <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= emit;
    end else if (kmers.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_code <= CODE_W'(history_next & code_mask);
      out_pos  <= (bases.base_pos - P_W'(k_eff - K_W'(1))) & POS_MASK;
    end
  end

endmodule
`default_nettype wire

>>> hdl/kws_checker.sv
// Port-level checks for the k-mer window sampler, bound to the top level.
`default_nettype none
module kws_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled request stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output register");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output is stalled");

  // A new result needs a base accepted in the cycle before.
  a_result_from_base: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc))
    else $error("result without an accepted base");

endmodule

bind kmer_window_sampler_core kws_checker u_kws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bases.valid),
  .in_ready  (bases.ready),
  .out_valid (kmers.valid),
  .out_ready (kmers.ready)
);
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the k-mer window sampler core.
`timescale 1ns / 100ps

module tb_top;
  import kws_pkg::*;

  typedef struct packed {
    base_t base;
    logic  first;
    pos_t  pos;
  } base_req_t;

  typedef struct packed {
    code_t code;
    pos_t  pos;
  } kmer_exp_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  kws_base_if base_ch ();
  kws_kmer_if kmer_ch ();

  kmer_window_sampler_core dut (
    .clk       (clk),
    .rst       (rst),
    .bases     (base_ch),
    .kmers     (kmer_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  base_req_t pending_bases[$];
  kmer_exp_t expected_kmers[$];
  int unsigned errors;
  bit steady;
  bit base_sent;

  // Shadow of the sampler's registers and state
  ksize_t kmer_len;
  wsize_t stride;
  hist_t  history;
  int unsigned filled;
  wsize_t since_emit;
  bit     emitted;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_kmer_len();
    if (kmer_len == 0) return 1;
    if (kmer_len > MAX_KMER) return MAX_KMER;
    return kmer_len;
  endfunction

  function automatic void sample_kmer(base_t b, logic first, pos_t pos);
    int unsigned k;
    int unsigned w;
    bit fire;
    kmer_exp_t r;
    k = eff_kmer_len();
    w = (stride == 0) ? 1 : stride;
    fire = 1'b0;
    if (first) begin
      history = '0;
      filled = 0;
      since_emit = '0;
      emitted = 1'b0;
    end
    history = {history[HIST_W-3:0], b};
    if (filled < MAX_KMER) filled++;
    if (filled >= k) begin
      if (!emitted) begin
        fire = 1'b1;
        emitted = 1'b1;
        since_emit = '0;
      end else begin
        since_emit = since_emit + 1'b1;
        if (since_emit >= w) begin
          fire = 1'b1;
          since_emit = '0;
        end
      end
    end
    if (fire) begin
      r.code = (k >= 32) ? history : history & ((64'd1 << (2 * k)) - 64'd1);
      r.pos  = (pos - pos_t'(k - 1)) & POS_MASK;
      expected_kmers.push_back(r);
    end
  endfunction

  // Base driver: a new request goes out only once the last one was taken
  always @(negedge clk) begin
    base_req_t nxt;
    if (rst) begin
      base_ch.valid <= 1'b0;
    end else if (!base_ch.valid || base_sent) begin
      base_sent = 1'b0;
      if (pending_bases.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
        nxt = pending_bases.pop_front();
        base_ch.valid        <= 1'b1;
        base_ch.base         <= nxt.base;
        base_ch.first_of_seq <= nxt.first;
        base_ch.base_pos     <= nxt.pos;
      end else begin
        base_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    kmer_ch.ready <= !rst && (steady || $urandom_range(99) >= 32);
  end

  // Check outputs first: a k-mer always trails the base that completes it
  always @(posedge clk) begin
    kmer_exp_t want;
    if (!rst) begin
      if (kmer_ch.valid && kmer_ch.ready) begin
        if (expected_kmers.size() == 0) begin
          errors++;
          $display("%0t: kmer expected none, got code %h pos %h",
                   $time, kmer_ch.kmer_code, kmer_ch.kmer_pos);
        end else begin
          want = expected_kmers.pop_front();
          if (kmer_ch.kmer_code !== want.code) begin
            errors++;
            $display("%0t: kmer_code expected %h, got %h",
                     $time, want.code, kmer_ch.kmer_code);
          end
          if (kmer_ch.kmer_pos !== want.pos) begin
            errors++;
            $display("%0t: kmer_pos expected %h, got %h",
                     $time, want.pos, kmer_ch.kmer_pos);
          end
        end
      end
      if (base_ch.valid && base_ch.ready) begin
        sample_kmer(base_ch.base, base_ch.first_of_seq, base_ch.base_pos);
        base_sent = 1'b1;
      end
    end
  end

  task automatic push_base(base_t b, logic first, pos_t pos);
    base_req_t r;
    r.base  = b;
    r.first = first;
    r.pos   = pos;
    pending_bases.push_back(r);
  endtask

  task automatic set_reg(cfg_index_t idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cfg_data_t'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KMER_SIZE) kmer_len = ksize_t'(val);
    else stride = wsize_t'(val);
  endtask

  task automatic settle();
    while (pending_bases.size() != 0 || base_ch.valid || expected_kmers.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Mostly well-formed sequences with consecutive offsets, some stray bases
  task automatic gen_phase(int unsigned count);
    int unsigned made;
    int unsigned len;
    int unsigned ke;
    int unsigned we;
    bit flag;
    pos_t p;
    made = 0;
    flag = 1'($urandom_range(1));
    while (made < count) begin
      if ($urandom_range(99) < 15) begin
        push_base(base_t'($urandom_range(3)), 1'($urandom_range(1)), pos_t'($urandom()));
        made++;
        flag = 1'b1;
      end else begin
        ke = eff_kmer_len();
        we = (stride == 0) ? 1 : stride;
        len = ke + 3 * we + 2;
        if (len > 80) len = 80;
        len = $urandom_range(1, len);
        if (len > count - made) len = count - made;
        if ($urandom_range(3) == 0) p = pos_t'(0) - pos_t'($urandom_range(1, 40));
        else p = pos_t'($urandom());
        for (int i = 0; i < len; i++)
          push_base(base_t'($urandom_range(3)), flag && i == 0, p + pos_t'(i));
        made += len;
        flag = 1'b1;
      end
    end
  endtask

  initial begin
    int unsigned kv;
    int unsigned wv;
    errors = 0;
    steady = 1'b0;
    base_sent = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_KMER_SIZE;
    cfg_data = '0;
    base_ch.valid = 1'b0;
    base_ch.base = '0;
    base_ch.first_of_seq = 1'b0;
    base_ch.base_pos = '0;
    kmer_ch.ready = 1'b0;
    kmer_len = ksize_t'(15);
    stride = wsize_t'(1);
    history = '0;
    filled = 0;
    since_emit = '0;
    emitted = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, no start flag, offsets wrapping through zero
    for (int i = 0; i < 17; i++) push_base(base_t'(i % 4), 1'b0, 32'hFFFF_FFF8 + i);
    settle();
    // Zero registers read as one
    set_reg(CFG_KMER_SIZE, 0);
    set_reg(CFG_WINDOW_SIZE, 0);
    push_base(2'd3, 1'b1, 32'd0);
    push_base(2'd2, 1'b0, 32'hFFFF_FFFF);
    push_base(2'd1, 1'b1, 32'd7);
    settle();
    // Oversized k clamps to the max; this sequence is too short to emit
    set_reg(CFG_KMER_SIZE, 40);
    set_reg(CFG_WINDOW_SIZE, 1);
    for (int i = 0; i < 5; i++) push_base(base_t'(i), i == 0, pos_t'(100 + i));
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin kv = 32; wv = 1023; end
        1: begin kv = 1;  wv = 1;    end
        2: begin kv = 63; wv = 2;    end
        default: begin
          kv = ($urandom_range(4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
          case ($urandom_range(3))
            0: wv = 1023;
            1: wv = $urandom_range(0, 1023);
            default: wv = $urandom_range(0, 6);
          endcase
        end
      endcase
      // later phases sometimes change one register only, mid-sequence
      if (ph < 3 || $urandom_range(2) != 0) set_reg(CFG_KMER_SIZE, kv);
      if (ph < 3 || $urandom_range(2) != 0) set_reg(CFG_WINDOW_SIZE, wv);
      steady = (ph == 4);
      gen_phase(50);
      settle();
    end
    steady = 1'b0;
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> sim.f
hdl/kws_pkg.sv
hdl/kws_if.sv
hdl/kmer_window_sampler_core.sv
hdl/kws_checker.sv
tb/sv/tb_top.sv
